// File: sv/black_border_mean_fill_assert.svh
// assertion macros for the border mean fill block
`ifndef BLACK_BORDER_MEAN_FILL_ASSERT_SVH
`define BLACK_BORDER_MEAN_FILL_ASSERT_SVH

// same-cycle implication, checked on clk outside reset
`define BBMF_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked on clk outside reset
`define BBMF_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: sv/bbmf_pkg.sv
// shared types and constants of the border mean fill block
package bbmf_pkg;

  localparam int PIX_W      = 8;
  localparam int PIX_MAX    = 255;
  localparam int CFG_W      = 11;
  localparam int CFG_ADDR_W = 1;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // request kinds
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } op_t;

  // classified request held in the queue
  typedef struct packed {
    op_t              op;
    logic [PIX_W-1:0] pixel;
  } cmd_t;

  // divider control from the top level
  typedef struct packed {
    logic start;
    logic abort;
  } div_ctl_t;

endpackage

// File: sv/bbmf_front.sv
// front end: accepts requests, classifies them and queues them two deep
module bbmf_front
  import bbmf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [PIX_W-1:0] in_tdata,   // [7:0] pixel_in
  input  logic [0:0]       in_tuser,   // [0] opcode
  output cmd_t             head,
  output logic             head_v,
  input  logic             pop
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  cmd_t       cmd_in;

  // classify the incoming request; a read carries no pixel
  always_comb begin
    cmd_in.op    = op_t'(in_tuser[0]);
    cmd_in.pixel = (cmd_in.op == OP_READ) ? '0 : in_tdata;
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign head_v    = (cnt_r != 2'd0);
  assign head      = q_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// File: sv/bbmf_div.sv
// mean unit: restoring divider, one quotient bit per cycle, then rounding
module bbmf_div
  import bbmf_pkg::*;
#(
  parameter int SUM_W = 28,
  parameter int CNT_W = 21
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_ctl_t         ctl,
  input  logic [SUM_W-1:0] sum,
  input  logic [CNT_W-1:0] cnt,
  output logic             busy,
  output logic [PIX_W-1:0] mean
);

  localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  typedef enum logic [2:0] {
    DIV_IDLE  = 3'b001,
    DIV_RUN   = 3'b010,
    DIV_ROUND = 3'b100
  } div_state_t;

  div_state_t        state_r, state_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]  den_r;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [PIX_W-1:0]  mean_r, mean_nxt;
  logic [CNT_W:0]    rem_sh;
  logic              ge;
  logic [CNT_W:0]    rem_dbl;
  logic              up;
  logic [SUM_W:0]    q_inc;

  // one restoring step
  always_comb begin
    rem_sh = {rem_r[CNT_W-1:0], quo_r[SUM_W-1]};
    ge     = (rem_sh >= {1'b0, den_r});
  end

  // round to nearest, ties to even, saturate at the pixel maximum
  always_comb begin
    rem_dbl = {rem_r[CNT_W-1:0], 1'b0};
    up      = (rem_dbl > {1'b0, den_r}) || ((rem_dbl == {1'b0, den_r}) && quo_r[0]);
    q_inc   = {1'b0, quo_r} + (SUM_W+1)'(up);
  end

  always_comb begin
    state_nxt = state_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    mean_nxt  = mean_r;
    unique case (state_r)
      DIV_IDLE: begin
        if (ctl.start) begin
          quo_nxt   = sum;
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = DIV_RUN;
        end
      end
      DIV_RUN: begin
        quo_nxt  = {quo_r[SUM_W-2:0], ge};
        rem_nxt  = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(SUM_W - 1)) begin
          state_nxt = DIV_ROUND;
        end
      end
      DIV_ROUND: begin
        if (den_r == '0) begin
          mean_nxt = '0;
        end else if (q_inc > (SUM_W+1)'(PIX_MAX)) begin
          mean_nxt = PIX_W'(PIX_MAX);
        end else begin
          mean_nxt = q_inc[PIX_W-1:0];
        end
        state_nxt = DIV_IDLE;
      end
      default: state_nxt = DIV_IDLE;
    endcase
    if (ctl.abort) begin
      state_nxt = DIV_IDLE;
      mean_nxt  = mean_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
      mean_r  <= '0;
    end else begin
      state_r <= state_nxt;
      mean_r  <= mean_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    if (state_r == DIV_IDLE && ctl.start) begin
      den_r <= cnt;
    end
  end

  assign busy = (state_r != DIV_IDLE);
  assign mean = mean_r;

endmodule

// File: sv/bbmf_back.sv
// back end: frame store, row extents, readout pipeline and output register
module bbmf_back
  import bbmf_pkg::*;
#(
  parameter int CW    = 10,
  parameter int RW    = 10,
  parameter int CNT_W = 21,
  parameter int SUM_W = 28
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             restart,
  input  logic [CW-1:0]    last_col,
  input  logic [RW-1:0]    last_row,
  input  cmd_t             head,
  input  logic             head_v,
  output logic             pop,
  input  logic             div_busy,
  input  logic [PIX_W-1:0] mean,
  output logic             div_start,
  output logic [SUM_W-1:0] div_sum,
  output logic [CNT_W-1:0] div_cnt,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [PIX_W-1:0] out_tdata,  // [7:0] pixel_out
  output logic [1:0]       out_tuser,  // [0] row_end, [1] not_ready
  output logic             out_tlast   // frame_end
);

  localparam int AW    = RW + CW;
  localparam int ROW_W = 2 * CW + 1;

  // storage
  logic [PIX_W-1:0] frame_mem [2**AW];
  logic [ROW_W-1:0] row_mem   [2**RW];

  // frame state
  logic [CW-1:0]    load_col_r, load_col_nxt;
  logic [RW-1:0]    load_row_r, load_row_nxt;
  logic [CW-1:0]    rd_col_r, rd_col_nxt;
  logic [RW-1:0]    rd_row_r, rd_row_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             full_r, full_nxt;
  logic             run_has_r, run_has_nxt;
  logic [CW-1:0]    run_first_r, run_first_nxt;
  logic [CW-1:0]    run_last_r, run_last_nxt;

  // readout stage and output register
  logic             s1_v_r;
  logic             s1_nr_r, s1_rend_r, s1_fend_r;
  logic [CW-1:0]    s1_col_r;
  logic [PIX_W-1:0] s1_mean_r;
  logic [PIX_W-1:0] pix_q_r;
  logic [ROW_W-1:0] row_q_r;
  logic             out_v_r;
  logic [PIX_W-1:0] out_pix_r, out_pix_nxt;
  logic             out_rend_r, out_fend_r, out_nr_r;

  // handshake and issue control
  logic             out_free, s1_move, s1_free;
  logic             do_load, do_read, rd_issue;
  logic [CW-1:0]    col_e;
  logic [RW-1:0]    row_e;
  logic [SUM_W-1:0] sum_e;
  logic [CNT_W-1:0] cnt_e;
  logic             has_e, px_nz, row_done, frame_done;
  logic             rd_rend, rd_fend;
  logic             row_has_q, fill;
  logic [CW-1:0]    row_first_q, row_last_q;

  assign out_free  = !out_v_r || out_tready;
  assign s1_move   = s1_v_r && out_free;
  assign s1_free   = !s1_v_r || out_free;
  assign pop       = head_v && !div_busy && ((head.op == OP_LOAD) || s1_free);
  assign do_load   = pop && (head.op == OP_LOAD);
  assign do_read   = pop && (head.op == OP_READ);
  assign rd_issue  = do_read && full_r;

  // load: a full store restarts the frame with this pixel
  always_comb begin
    col_e         = full_r ? '0 : load_col_r;
    row_e         = full_r ? '0 : load_row_r;
    sum_e         = full_r ? '0 : sum_r;
    cnt_e         = full_r ? '0 : cnt_r;
    px_nz         = (head.pixel != '0);
    has_e         = (col_e == '0) ? 1'b0 : run_has_r;
    run_has_nxt   = has_e || px_nz;
    run_first_nxt = (px_nz && !has_e) ? col_e : run_first_r;
    run_last_nxt  = px_nz ? col_e : run_last_r;
    sum_nxt       = sum_e + SUM_W'(head.pixel);
    cnt_nxt       = cnt_e + CNT_W'(px_nz);
    row_done      = (col_e == last_col);
    frame_done    = row_done && (row_e == last_row);
  end

  // readout position and end flags
  always_comb begin
    rd_rend = (rd_col_r == last_col);
    rd_fend = rd_rend && (rd_row_r == last_row);
  end

  // next positions and frame status
  always_comb begin
    load_col_nxt = load_col_r;
    load_row_nxt = load_row_r;
    rd_col_nxt   = rd_col_r;
    rd_row_nxt   = rd_row_r;
    full_nxt     = full_r;
    if (do_load) begin
      full_nxt = 1'b0;
      if (row_done) begin
        load_col_nxt = '0;
        if (frame_done) begin
          load_row_nxt = '0;
          full_nxt     = 1'b1;
          rd_col_nxt   = '0;
          rd_row_nxt   = '0;
        end else begin
          load_row_nxt = row_e + 1'b1;
        end
      end else begin
        load_col_nxt = col_e + 1'b1;
      end
    end else if (rd_issue) begin
      if (rd_rend) begin
        rd_col_nxt = '0;
        rd_row_nxt = rd_fend ? '0 : rd_row_r + 1'b1;
      end else begin
        rd_col_nxt = rd_col_r + 1'b1;
      end
    end
  end

  assign div_start = do_load && frame_done;
  assign div_sum   = sum_nxt;
  assign div_cnt   = cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      load_col_r <= '0;
      load_row_r <= '0;
      rd_col_r   <= '0;
      rd_row_r   <= '0;
      sum_r      <= '0;
      cnt_r      <= '0;
      full_r     <= 1'b0;
    end else begin
      load_col_r <= load_col_nxt;
      load_row_r <= load_row_nxt;
      rd_col_r   <= rd_col_nxt;
      rd_row_r   <= rd_row_nxt;
      full_r     <= full_nxt;
      if (do_load) begin
        sum_r <= sum_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  // running extent of the row being loaded
  always_ff @(posedge clk) begin
    if (do_load) begin
      run_has_r   <= run_has_nxt;
      run_first_r <= run_first_nxt;
      run_last_r  <= run_last_nxt;
    end
  end

  // frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (do_load) begin
      frame_mem[{row_e, col_e}] <= head.pixel;
    end
    if (rd_issue) begin
      pix_q_r <= frame_mem[{rd_row_r, rd_col_r}];
    end
  end

  // row extent table, written at the end of each loaded row
  always_ff @(posedge clk) begin
    if (do_load && row_done) begin
      row_mem[row_e] <= {run_has_nxt, run_first_nxt, run_last_nxt};
    end
    if (rd_issue) begin
      row_q_r <= row_mem[rd_row_r];
    end
  end

  // readout stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (do_read) begin
      s1_v_r <= 1'b1;
    end else if (s1_move) begin
      s1_v_r <= 1'b0;
    end
  end

  // readout stage payload, mean taken at issue
  always_ff @(posedge clk) begin
    if (do_read) begin
      s1_nr_r   <= !full_r;
      s1_rend_r <= full_r && rd_rend;
      s1_fend_r <= full_r && rd_fend;
      s1_col_r  <= rd_col_r;
      s1_mean_r <= mean;
    end
  end

  // border fill decision
  always_comb begin
    row_has_q   = row_q_r[ROW_W-1];
    row_first_q = row_q_r[2*CW-1:CW];
    row_last_q  = row_q_r[CW-1:0];
    fill        = !row_has_q || (s1_col_r < row_first_q) || (s1_col_r > row_last_q);
    if (s1_nr_r) begin
      out_pix_nxt = '0;
    end else if (fill) begin
      out_pix_nxt = s1_mean_r;
    end else begin
      out_pix_nxt = pix_q_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_move) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_pix_r  <= out_pix_nxt;
      out_rend_r <= s1_rend_r;
      out_fend_r <= s1_fend_r;
      out_nr_r   <= s1_nr_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_pix_r;
  assign out_tuser  = {out_nr_r, out_rend_r};
  assign out_tlast  = out_fend_r;

endmodule

// File: sv/black_border_mean_fill.sv
// top level of the border mean fill block: frame size registers and wiring
//
//  channel  | direction | contents
//  in_      | slave     | tdata pixel_in, tuser opcode
//  out_     | master    | tdata pixel_out, tuser {not_ready, row_end}, tlast frame_end
//  cfg_     | write     | cfg_addr 0 frame_width, 1 frame_height
//
// loads and readouts execute at one per cycle through a two-deep request queue
// while the mean divider is idle and, for readouts, the output is not stalled;
// a readout result passes the readout stage, then the output register; after a frame's
// last load the mean divider runs one quotient bit per cycle; no request executes then.
// reset is synchronous; the frame store and row table have no reset and no sweep.
// output stalls back up through the readout stage into the queue and in_tready.
`include "black_border_mean_fill_assert.svh"

module black_border_mean_fill
  import bbmf_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,   // [7:0] pixel_in
  input  logic [0:0]            in_tuser,   // [0] opcode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [PIX_W-1:0]      out_tdata,  // [7:0] pixel_out
  output logic [1:0]            out_tuser,  // [0] row_end, [1] not_ready
  output logic                  out_tlast,  // frame_end
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int NPIX  = MAX_WIDTH * MAX_HEIGHT;
  localparam int CNT_W = $clog2(NPIX + 1);
  localparam int SUM_W = CNT_W + PIX_W;
  localparam int RST_LAST_COL = ((1024 > MAX_WIDTH) ? MAX_WIDTH : 1024) - 1;
  localparam int RST_LAST_ROW = ((1024 > MAX_HEIGHT) ? MAX_HEIGHT : 1024) - 1;

  // last index of a dimension, zero acting as one and clamped to the maximum
  function automatic int last_index(input logic [CFG_W-1:0] v, input int mx);
    int vi;
    vi = int'(v);
    if (vi == 0) return 0;
    if (vi > mx) return mx - 1;
    return vi - 1;
  endfunction

  logic [CW-1:0]    last_col_r;
  logic [RW-1:0]    last_row_r;
  cmd_t             head;
  logic             head_v;
  logic             pop;
  logic             div_busy;
  logic [PIX_W-1:0] mean;
  logic             div_start;
  logic [SUM_W-1:0] div_sum;
  logic [CNT_W-1:0] div_cnt;
  div_ctl_t         div_ctl;

  // frame size registers, kept as last column and last row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r <= CW'(RST_LAST_COL);
      last_row_r <= RW'(RST_LAST_ROW);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FRAME_WIDTH:  last_col_r <= CW'(last_index(cfg_wdata, MAX_WIDTH));
        REG_FRAME_HEIGHT: last_row_r <= RW'(last_index(cfg_wdata, MAX_HEIGHT));
      endcase
    end
  end

  // any size write abandons the frame and any mean in progress
  always_comb begin
    div_ctl.start = div_start;
    div_ctl.abort = cfg_we;
  end

  bbmf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .head      (head),
    .head_v    (head_v),
    .pop       (pop)
  );

  bbmf_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .sum   (div_sum),
    .cnt   (div_cnt),
    .busy  (div_busy),
    .mean  (mean)
  );

  bbmf_back #(
    .CW    (CW),
    .RW    (RW),
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (cfg_we),
    .last_col   (last_col_r),
    .last_row   (last_row_r),
    .head       (head),
    .head_v     (head_v),
    .pop        (pop),
    .div_busy   (div_busy),
    .mean       (mean),
    .div_start  (div_start),
    .div_sum    (div_sum),
    .div_cnt    (div_cnt),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // checks
  `BBMF_ASSERT_NOW(a_nr_clean, out_tvalid && out_tuser[1], (out_tdata == '0) && !out_tlast && !out_tuser[0], "not_ready result carries data")
  `BBMF_ASSERT_NOW(a_fend_rend, out_tvalid && out_tlast, out_tuser[0], "frame end without row end")
  `BBMF_ASSERT_NOW(a_hold_div, div_busy, !pop, "request executed while mean in progress")
  `BBMF_ASSERT_NEXT(a_div_runs, div_start && !cfg_we, div_busy, "mean unit did not start")

endmodule
